// ===== rtl/tmb_pkg.sv =====
// shared constants and types for the trimmed batch mean block
`timescale 1ns / 1ps
package tmb_pkg;

    // batch shape
    localparam int unsigned SAMPLES = 32;
    localparam int unsigned WARMUP  = 2;
    localparam int unsigned TRIM    = 4;

    // field widths
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned MEAN_W   = 40;
    localparam int unsigned FRAC_W   = 8;

    // derived sizes
    localparam int          KEPT      = int'(SAMPLES) - int'(WARMUP) - 2 * int'(TRIM);
    localparam bit          HAS_KEPT  = (KEPT > 0) && (WARMUP < SAMPLES);
    localparam int unsigned KEPT_SAFE = (KEPT > 0) ? KEPT : 1;
    localparam int unsigned CNT_W     = $clog2(SAMPLES);
    localparam int unsigned SUM_W     = SAMPLE_W + $clog2(SAMPLES);
    localparam int unsigned DIV_W     = SUM_W + FRAC_W;
    localparam int unsigned LIST_D    = (TRIM > 0) ? TRIM : 1;
    localparam int unsigned TRIM_CW   = $clog2(TRIM + 2);

    // reciprocal multiply for the mean: sum * RECIP >> QUOT_SH is exact for every sum
    localparam int unsigned MUL_DIG_W = 8;
    localparam int unsigned MUL_STEPS = (SUM_W + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int unsigned MUL_IN_W  = MUL_STEPS * MUL_DIG_W;
    localparam int unsigned STEP_W    = $clog2(MUL_STEPS);
    localparam int unsigned RECIP_SH  = DIV_W + $clog2(KEPT_SAFE);
    localparam int unsigned RECIP_W   = DIV_W + 1;
    localparam logic [63:0] RECIP     = ((64'd1 << RECIP_SH) + 64'(KEPT_SAFE) - 64'd1)
                                        / 64'(KEPT_SAFE);
    localparam int unsigned PART_W    = RECIP_W + MUL_DIG_W;
    localparam int unsigned PROD_W    = MUL_IN_W + RECIP_W;
    localparam int unsigned QUOT_SH   = RECIP_SH - FRAC_W;

    // queue between front and back
    localparam int unsigned FIFO_D  = 2;
    localparam int unsigned FIFO_AW = $clog2(FIFO_D);

    // one classified sample beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                keep;
        logic                last;
    } tmb_item_t;

    // request from the back end to the divider
    typedef struct packed {
        logic             go;
        logic [SUM_W-1:0] sum;
    } tmb_div_req_t;

endpackage

// ===== rtl/trimmed_mean_of_batch.sv =====
// top level: trimmed mean of a batch of timing samples
// throughput: one sample beat a cycle while busy is low; the queue stops draining during the trim
//   pass after each closing beat and while a closing beat waits for the divider, so busy rises
// latency: the mean_valid strobe follows the closing beat through the trim pass and the bytewise
//   reciprocal multiply
// the receiver cannot stall: each result is shown for one cycle only
// reset: asynchronous, active low; clears batch position, queue, sums and divider
`timescale 1ns / 1ps
module trimmed_mean_of_batch
    import tmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                mean_valid,
    output logic [MEAN_W-1:0]   mean_q8
);

    logic         push;
    tmb_item_t    push_item;
    logic         q_full;
    logic         q_not_empty;
    tmb_item_t    q_head;
    logic         pop;
    logic         div_busy;
    tmb_div_req_t div_req;

    // classify incoming beats
    tmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sample    (sample),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    tmb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // accumulate and trim
    tmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (q_head),
        .div_busy   (div_busy),
        .pop        (pop),
        .div_req    (div_req)
    );

    // scaled mean
    tmb_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .div_req    (div_req),
        .div_busy   (div_busy),
        .mean_valid (mean_valid),
        .mean_q8    (mean_q8)
    );

endmodule

// ===== rtl/tmb_front.sv =====
// front end: takes sample beats, tracks batch position and tags each beat
`timescale 1ns / 1ps
module tmb_front
    import tmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                q_full,
    output logic                busy,
    output logic                push,
    output tmb_item_t           push_item
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_last;

    // accept whenever the queue has room
    assign busy    = q_full;
    assign push    = start && !q_full;
    assign is_last = (count_reg == CNT_W'(SAMPLES - 1));

    // tag the beat: warmup beats are dropped by the back end
    assign push_item.sample = sample;
    assign push_item.keep   = (32'(count_reg) >= WARMUP);
    assign push_item.last   = is_last;

    // position within the batch
    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = is_last ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/tmb_fifo.sv =====
// short queue of tagged beats between front and back end
`timescale 1ns / 1ps
module tmb_fifo
    import tmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tmb_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output tmb_item_t head
);

    tmb_item_t          mem_reg [FIFO_D];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fill_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   fill_next;

    assign full      = (fill_reg == (FIFO_AW + 1)'(FIFO_D));
    assign not_empty = (fill_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/tmb_back.sv =====
// back end: running sum plus the smallest and largest kept samples, trimmed at batch end
`timescale 1ns / 1ps
module tmb_back
    import tmb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  tmb_item_t    item,
    input  logic         div_busy,
    output logic         pop,
    output tmb_div_req_t div_req
);

    typedef enum logic [0:0] {
        ST_ACC,
        ST_TRIM
    } state_t;

    localparam logic [SAMPLE_W-1:0] MIN_SENT = '1;
    localparam logic [SAMPLE_W-1:0] MAX_SENT = '0;

    state_t              state_reg;
    state_t              state_next;
    logic [SUM_W-1:0]    total_reg;
    logic [SUM_W-1:0]    total_next;
    logic [TRIM_CW-1:0]  cnt_reg;
    logic [TRIM_CW-1:0]  cnt_next;
    logic [SAMPLE_W-1:0] min_reg [LIST_D];
    logic [SAMPLE_W-1:0] min_next [LIST_D];
    logic [SAMPLE_W-1:0] max_reg [LIST_D];
    logic [SAMPLE_W-1:0] max_next [LIST_D];
    logic                go_reg;
    logic                go_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] v;

    assign div_req.go  = go_reg;
    assign div_req.sum = sum_reg;
    assign v           = item.sample;
    assign pair_sum    = {1'b0, min_reg[0]} + {1'b0, max_reg[0]};

    // a closing beat waits until the divider is free
    assign pop = item_valid && (state_reg == ST_ACC)
                 && !(item.last && (div_busy || go_reg));

    // next state, list insertion and trimming
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        cnt_next   = cnt_reg;
        go_next    = 1'b0;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (pop)
                begin
                    if (item.keep)
                    begin
                        total_next = total_reg + SUM_W'(v);
                        // sorted insert into the smallest-so-far and largest-so-far lists
                        for (int i = 0; i < int'(LIST_D); i++)
                        begin
                            if (v < min_reg[i])
                            begin
                                min_next[i] = (i > 0 && v < min_reg[(i > 0) ? i - 1 : 0])
                                              ? min_reg[(i > 0) ? i - 1 : 0] : v;
                            end
                            if (v > max_reg[i])
                            begin
                                max_next[i] = (i > 0 && v > max_reg[(i > 0) ? i - 1 : 0])
                                              ? max_reg[(i > 0) ? i - 1 : 0] : v;
                            end
                        end
                    end
                    if (item.last)
                    begin
                        state_next = ST_TRIM;
                        cnt_next   = '0;
                    end
                end
            end
            ST_TRIM:
            begin
                if (cnt_reg == TRIM_CW'(TRIM))
                begin
                    // hand the trimmed sum to the divider and open a new batch
                    go_next    = 1'b1;
                    sum_next   = total_reg;
                    total_next = '0;
                    state_next = ST_ACC;
                    for (int i = 0; i < int'(LIST_D); i++)
                    begin
                        min_next[i] = MIN_SENT;
                        max_next[i] = MAX_SENT;
                    end
                end
                else
                begin
                    // drop one smallest and one largest per cycle
                    total_next = total_reg - SUM_W'(pair_sum);
                    cnt_next   = cnt_reg + 1'b1;
                    for (int i = 0; i < int'(LIST_D); i++)
                    begin
                        if (i == int'(LIST_D) - 1)
                        begin
                            min_next[i] = MIN_SENT;
                            max_next[i] = MAX_SENT;
                        end
                        else
                        begin
                            min_next[i] = min_reg[(i < int'(LIST_D) - 1) ? i + 1 : i];
                            max_next[i] = max_reg[(i < int'(LIST_D) - 1) ? i + 1 : i];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            total_reg <= '0;
            cnt_reg   <= '0;
            go_reg    <= 1'b0;
            sum_reg   <= '0;
            for (int i = 0; i < int'(LIST_D); i++)
            begin
                min_reg[i] <= MIN_SENT;
                max_reg[i] <= MAX_SENT;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            go_reg    <= go_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

endmodule

// ===== rtl/tmb_div.sv =====
// divider: scaled sum times a fixed reciprocal of the kept count, one byte of the sum a cycle
`timescale 1ns / 1ps
module tmb_div
    import tmb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tmb_div_req_t      div_req,
    output logic              div_busy,
    output logic              mean_valid,
    output logic [MEAN_W-1:0] mean_q8
);

    typedef enum logic [0:0] {
        DV_IDLE,
        DV_RUN
    } state_t;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    state_t                state_reg;
    state_t                state_next;
    logic [MUL_IN_W-1:0]   src_reg;
    logic [MUL_IN_W-1:0]   src_next;
    logic [PROD_W-1:0]     acc_reg;
    logic [PROD_W-1:0]     acc_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [MEAN_W-1:0]     mean_reg;
    logic [MEAN_W-1:0]     mean_next;
    logic [MUL_DIG_W-1:0]  digit;
    logic [PART_W-1:0]     part;

    assign div_busy   = (state_reg == DV_RUN);
    assign mean_valid = valid_reg;
    assign mean_q8    = mean_reg;

    // one partial product a cycle, top byte of the sum first
    assign digit = src_reg[MUL_IN_W-1 -: MUL_DIG_W];
    assign part  = PART_W'(RECIP_C) * PART_W'(digit);

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        valid_next = 1'b0;
        mean_next  = mean_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (div_req.go)
                begin
                    if (HAS_KEPT)
                    begin
                        src_next   = MUL_IN_W'(div_req.sum);
                        acc_next   = '0;
                        step_next  = '0;
                        state_next = DV_RUN;
                    end
                    else
                    begin
                        // nothing left to average
                        mean_next  = '0;
                        valid_next = 1'b1;
                    end
                end
            end
            DV_RUN:
            begin
                acc_next  = {acc_reg[PROD_W-MUL_DIG_W-1:0], MUL_DIG_W'(0)} + PROD_W'(part);
                src_next  = {src_reg[MUL_IN_W-MUL_DIG_W-1:0], MUL_DIG_W'(0)};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    mean_next  = MEAN_W'(acc_next >> QUOT_SH);
                    valid_next = 1'b1;
                    state_next = DV_IDLE;
                end
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            src_reg   <= '0;
            acc_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            mean_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            mean_reg  <= mean_next;
        end
    end

endmodule

// ===== test/trimmed_mean_of_batch_checker.sv =====
// checker for the trimmed batch mean: watches sample beats and mean strobes, predicts and compares
`timescale 1ns / 1ps
module trimmed_mean_of_batch_checker
    import tmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                mean_valid,
    input  logic [MEAN_W-1:0]   mean_q8,
    output int                  fail_count,
    output int                  means_pending,
    output int                  means_checked
);

    // own copy of the batch being collected
    logic [SAMPLE_W-1:0] batch_buf [SAMPLES];
    int unsigned         fill_pos;

    // means owed by the block, oldest first
    logic [MEAN_W-1:0]   mean_expected_q [$];

    int                  fails   = 0;
    int                  checked = 0;

    initial
    begin
        fail_count    = 0;
        means_pending = 0;
        means_checked = 0;
    end

    // mean of the batch after warm-up is dropped and both tails are trimmed
    function automatic logic [MEAN_W-1:0] batch_mean_q8();
        logic [SAMPLE_W-1:0] ordered [SAMPLES];
        logic [SAMPLE_W-1:0] v;
        logic [63:0]         total;
        logic [63:0]         quot;
        int                  n;
        int                  i;
        int                  j;

        if (!HAS_KEPT)
            return '0;
        n = int'(SAMPLES) - int'(WARMUP);
        for (i = 0; i < n; i++)
            ordered[i] = batch_buf[int'(WARMUP) + i];

        // ascending insertion sort, ties land in any order
        for (i = 1; i < n; i++)
        begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end

        total = '0;
        for (i = int'(TRIM); i < n - int'(TRIM); i++)
            total += 64'(ordered[i]);
        quot = (total << FRAC_W) / 64'(KEPT);
        return quot[MEAN_W-1:0];
    endfunction

    // accept beats, predict means, compare strobed results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos = 0;
            mean_expected_q.delete();
        end
        else
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                batch_buf[fill_pos] = sample;
                fill_pos++;
                if (fill_pos == SAMPLES)
                begin
                    fill_pos = 0;
                    mean_expected_q.push_back(batch_mean_q8());
                end
            end

            if (mean_valid === 1'b1)
            begin
                if (mean_expected_q.size() == 0)
                begin
                    $error("mean_q8: unexpected result, expected none, actual %h", mean_q8);
                    fails++;
                end
                else
                begin
                    logic [MEAN_W-1:0] exp_mean;
                    exp_mean = mean_expected_q.pop_front();
                    checked++;
                    if (mean_q8 !== exp_mean)
                    begin
                        $error("mean_q8 mismatch: expected %h, actual %h", exp_mean, mean_q8);
                        fails++;
                    end
                end
            end
        end

        fail_count    <= fails;
        means_pending <= mean_expected_q.size();
        means_checked <= checked;
    end

endmodule

// ===== test/trimmed_mean_of_batch_tb.sv =====
// testbench top for the trimmed batch mean: drives sample beats and gives the verdict
`timescale 1ns / 1ps
module trimmed_mean_of_batch_tb;
    import tmb_pkg::*;

    localparam int unsigned BATCHES      = 52;
    localparam int unsigned CALM_BATCHES = 6;
    localparam int unsigned PAUSE_BATCH  = BATCHES / 3;
    localparam int unsigned DRAIN_CYCLES = TRIM + DIV_W + 3 + 32;
    localparam int unsigned CYCLE_LIMIT  = 250000;

    // shapes of a random batch
    typedef enum int unsigned {
        PAT_RANDOM,
        PAT_TIES,
        PAT_FLAT,
        PAT_NEAR_MAX,
        PAT_RISING,
        PAT_FALLING,
        PAT_RAILS,
        PAT_OUTLIERS
    } batch_pat_e;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [SAMPLE_W-1:0] sample;
    logic                mean_valid;
    logic [MEAN_W-1:0]   mean_q8;

    int                  fail_count;
    int                  means_pending;
    int                  means_checked;
    int unsigned         beats_sent = 0;
    int unsigned         cycle_count = 0;

    trimmed_mean_of_batch u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .mean_valid (mean_valid),
        .mean_q8    (mean_q8)
    );

    trimmed_mean_of_batch_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .mean_valid    (mean_valid),
        .mean_q8       (mean_q8),
        .fail_count    (fail_count),
        .means_pending (means_pending),
        .means_checked (means_checked)
    );

    // 10 ns clock
    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("trimmed_mean_of_batch verification failed");
            $finish;
        end
    end

    // one sample beat, called and returning at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        start  <= 1'b1;
        sample <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // sender gap with junk on the data port
    task automatic idle_gap(input int unsigned n);
        start  <= 1'b0;
        sample <= $urandom;
        repeat (n)
            @(negedge clk);
    endtask

    // sample value for a given batch shape
    function automatic logic [SAMPLE_W-1:0] pattern_sample(input batch_pat_e pat,
                                                           input int unsigned idx,
                                                           input logic [SAMPLE_W-1:0] base);
        logic [SAMPLE_W-1:0] v;

        case (pat)
            PAT_TIES:     v = $urandom_range(0, 15);
            PAT_FLAT:     v = base;
            PAT_NEAR_MAX: v = {SAMPLE_W{1'b1}} - $urandom_range(0, 3);
            PAT_RISING:   v = base + idx;
            PAT_FALLING:  v = base - idx;
            PAT_RAILS:
            begin
                case ($urandom_range(0, 2))
                    0:       v = '0;
                    1:       v = {SAMPLE_W{1'b1}};
                    default: v = $urandom;
                endcase
            end
            PAT_OUTLIERS:
            begin
                if ($urandom_range(0, 7) == 0)
                    v = $urandom;
                else
                    v = 1000 + $urandom_range(0, 99);
            end
            default:      v = $urandom;
        endcase
        return v;
    endfunction

    // stimulus
    initial
    begin
        batch_pat_e          pat;
        int unsigned         pick;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] v;
        bit                  gappy;
        int unsigned         b;
        int unsigned         i;

        rst_n  = 1'b0;
        start  = 1'b0;
        sample = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed batch: maximal warm-up to be ignored, zeros and maxima in the tails, ties
        for (i = 0; i < SAMPLES; i++)
        begin
            if (i < WARMUP)
                v = {SAMPLE_W{1'b1}};
            else if ((i - WARMUP) % 7 == 0)
                v = '0;
            else if ((i - WARMUP) % 7 == 3)
                v = {SAMPLE_W{1'b1}};
            else
                v = 32'h8000_0001;
            send_sample(v);
        end

        // random batches of assorted shapes
        for (b = 0; b < BATCHES; b++)
        begin
            pick  = $urandom_range(0, 11);
            pat   = (pick > PAT_OUTLIERS) ? PAT_RANDOM : batch_pat_e'(pick);
            base  = $urandom;
            gappy = (b < BATCHES - CALM_BATCHES) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < SAMPLES; i++)
            begin
                if (gappy && $urandom_range(0, 4) == 0)
                    idle_gap($urandom_range(1, 9));
                send_sample(pattern_sample(pat, i, base));
            end

            // hold the sender off until the block has caught up
            if (b == PAUSE_BATCH)
            begin
                start <= 1'b0;
                while (means_pending != 0)
                    @(negedge clk);
            end
        end

        // drain and verdict
        start <= 1'b0;
        while (means_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("covered %0d sample beats in %0d batches with gaps, ties, rails and near-max values",
                 beats_sent, BATCHES + 1);
        $display("compared %0d trimmed means, %0d mismatches", means_checked, fail_count);
        if (fail_count == 0)
            $display("trimmed_mean_of_batch verification clean");
        else
            $display("trimmed_mean_of_batch verification failed");
        $finish;
    end

endmodule
